// ===== hdl/actuator_noise_and_bias_learning_top_assert.svh =====
// Assertion macros shared by the checker of the noise and bias learning block.
// Needs nothing else; take it in by a bare-name include.
`ifndef ACTUATOR_NOISE_AND_BIAS_LEARNING_TOP_ASSERT_SVH
`define ACTUATOR_NOISE_AND_BIAS_LEARNING_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ANBL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ANBL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/anbl_pkg.sv =====
// Types and constants of the actuator noise and bias learning block.
// No dependencies; imported by every other file but the queue and the macro header.
package anbl_pkg;

  localparam logic [9:0]  DutyMax  = 10'd1023;
  localparam logic [6:0]  PosSat   = 7'd106;
  localparam logic [6:0]  CountSat = 7'd100;
  localparam logic [7:0]  WaitSat  = 8'd200;

  typedef enum logic [2:0] {
    REG_INITIAL_DUTY      = 3'd0,
    REG_NOISE_TARGET      = 3'd1,
    REG_DEFAULT_NOISE     = 3'd2,
    REG_DUTY_STEP         = 3'd3,
    REG_DUTY_SEARCH_LIMIT = 3'd4,
    REG_TICKS_PER_STEP    = 3'd5,
    REG_BENCH_ENABLE      = 3'd6,
    REG_BENCH_DUTY        = 3'd7
  } anbl_reg_e;

  typedef enum logic [1:0] {
    CMD_IDLE,
    CMD_TICK,
    CMD_RESTART
  } anbl_cmd_e;

  typedef struct packed {
    logic        mode;
    logic        servo_enable;
    logic [15:0] cam_position;
    logic [15:0] pid_duty;
  } anbl_in_t;

  typedef struct packed {
    logic [9:0]  duty_out;
    logic        noise_learned;
    logic        rest_duty_learned;
    logic        learning_done;
    logic [6:0]  noise_level;
    logic [9:0]  current_duty;
    logic [15:0] integral_seed;
    logic [15:0] integral_memory;
  } anbl_out_t;

  typedef struct packed {
    logic [9:0]  initial_duty;
    logic [7:0]  noise_sample_target;
    logic [7:0]  default_noise;
    logic [9:0]  duty_step;
    logic [9:0]  duty_search_limit;
    logic [7:0]  ticks_per_step;
    logic        bench_enable;
    logic [15:0] bench_duty;
  } anbl_cfg_t;

  // Classified tick as it travels from front to back.
  typedef struct packed {
    anbl_cmd_e   kind;
    logic [15:0] pos;
    logic [6:0]  pos_sat;
    logic [9:0]  pid_sat;
  } anbl_cmd_t;

endpackage

// ===== hdl/anbl_fifo.sv =====
// Small first-in first-out queue of flops, any payload type.
// Depends on nothing; used between front and back and at the result side.
module anbl_fifo #(
  parameter type         T     = logic,
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T                mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hdl/anbl_front.sv =====
// Front end: classifies each accepted item and saturates its fields.
// Depends on anbl_pkg.
module anbl_front import anbl_pkg::*; (
  input  anbl_in_t  item_i,
  output anbl_cmd_t cmd_o
);

  always_comb begin
    // Classify: restart wins, a disabled tick only reports state.
    if (item_i.mode) begin
      cmd_o.kind = CMD_RESTART;
    end else if (item_i.servo_enable) begin
      cmd_o.kind = CMD_TICK;
    end else begin
      cmd_o.kind = CMD_IDLE;
    end
    cmd_o.pos     = item_i.cam_position;
    cmd_o.pos_sat = (item_i.cam_position > {9'd0, PosSat}) ? PosSat
                                                            : item_i.cam_position[6:0];
    cmd_o.pid_sat = (item_i.pid_duty > {6'd0, DutyMax}) ? DutyMax
                                                         : item_i.pid_duty[9:0];
  end

endmodule

// ===== hdl/anbl_back.sv =====
// Back end: noise learning, rest duty search and duty selection state.
// Depends on anbl_pkg; fed from the command queue, feeds the result queue.
module anbl_back import anbl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  anbl_cfg_t cfg_i,
  input  anbl_cmd_t cmd_i,
  input  logic      cmd_empty_i,
  output logic      cmd_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output anbl_out_t res_o
);

  logic [9:0]  search_q, search_d;
  logic [7:0]  wait_q, wait_d;
  logic [6:0]  hp_q, hp_d, lp_q, lp_d, sc_q, sc_d, noise_q, noise_d;
  logic        nf_q, nf_d, lf_q, lf_d;
  logic [15:0] seed_q, seed_d, mem_q, mem_d;
  logic [9:0]  held_q, held_d;
  logic [9:0]  back_duty;
  logic [10:0] sum_duty;
  logic [9:0]  bench_sat;

  assign cmd_pop_o  = !cmd_empty_i && !res_full_i;
  assign res_push_o = cmd_pop_o;
  assign bench_sat  = (cfg_i.bench_duty > {6'd0, DutyMax}) ? DutyMax : cfg_i.bench_duty[9:0];
  assign back_duty  = (search_q > cfg_i.duty_step) ? search_q - cfg_i.duty_step : 10'd0;
  assign sum_duty   = {1'b0, search_q} + {1'b0, cfg_i.duty_step};

  always_comb begin
    search_d = search_q;
    wait_d   = wait_q;
    hp_d     = hp_q;
    lp_d     = lp_q;
    sc_d     = sc_q;
    noise_d  = noise_q;
    nf_d     = nf_q;
    lf_d     = lf_q;
    seed_d   = seed_q;
    mem_d    = mem_q;
    held_d   = held_q;
    case (cmd_i.kind)
      CMD_RESTART: begin
        search_d = cfg_i.initial_duty;
        wait_d   = '0;
        hp_d     = '0;
        lp_d     = '0;
        sc_d     = '0;
        nf_d     = 1'b0;
        lf_d     = 1'b0;
        seed_d   = '0;
      end
      CMD_TICK: begin
        // Noise: track peaks, then fix the spread (the default noise if the target is zero) once enough samples are in.
        if (!nf_q) begin
          if (sc_q == '0) begin
            hp_d = cmd_i.pos_sat;
            lp_d = cmd_i.pos_sat;
          end else begin
            if (cmd_i.pos > {9'd0, hp_q}) hp_d = cmd_i.pos_sat;
            if (cmd_i.pos_sat < lp_q) lp_d = cmd_i.pos_sat;
          end
          sc_d = (sc_q >= CountSat) ? CountSat : sc_q + 7'd1;
          if ({1'b0, sc_d} >= cfg_i.noise_sample_target) begin
            if (cfg_i.noise_sample_target == '0) begin
              noise_d = (cfg_i.default_noise > {1'b0, PosSat}) ? PosSat
                                                                : cfg_i.default_noise[6:0];
            end else begin
              noise_d = (hp_d > lp_d) ? hp_d - lp_d : 7'd0;
            end
            nf_d = 1'b1;
          end
        end
        // Rest duty: step up until movement shows or the limit is passed.
        if (nf_d && !lf_q) begin
          if ({8'd0, noise_d, 1'b0} < cmd_i.pos || search_q > cfg_i.duty_search_limit) begin
            lf_d     = 1'b1;
            seed_d   = {back_duty, 6'd0};
            mem_d    = {back_duty, 6'd0};
            search_d = back_duty;
          end else begin
            lf_d  = 1'b0;
            mem_d = seed_q;
            if (wait_q < cfg_i.ticks_per_step) begin
              wait_d = wait_q + 8'd1;
            end else begin
              search_d = (sum_duty > {1'b0, DutyMax}) ? DutyMax : sum_duty[9:0];
              wait_d   = '0;
            end
            if (wait_d > WaitSat) wait_d = WaitSat;
          end
        end
        if (cfg_i.bench_enable) begin
          held_d = bench_sat;
        end else if (lf_d) begin
          held_d = cmd_i.pid_sat;
        end else begin
          held_d = search_d;
        end
      end
      default: ;
    endcase

    res_o.duty_out          = held_d;
    res_o.noise_learned     = nf_d;
    res_o.rest_duty_learned = lf_d;
    res_o.learning_done     = nf_d && lf_d;
    res_o.noise_level       = noise_d;
    res_o.current_duty      = search_d;
    res_o.integral_seed     = seed_d;
    res_o.integral_memory   = mem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_q <= '0;
      wait_q   <= '0;
      hp_q     <= '0;
      lp_q     <= '0;
      sc_q     <= '0;
      noise_q  <= '0;
      nf_q     <= 1'b0;
      lf_q     <= 1'b0;
      seed_q   <= '0;
      mem_q    <= '0;
      held_q   <= '0;
    end else if (cmd_pop_o) begin
      search_q <= search_d;
      wait_q   <= wait_d;
      hp_q     <= hp_d;
      lp_q     <= lp_d;
      sc_q     <= sc_d;
      noise_q  <= noise_d;
      nf_q     <= nf_d;
      lf_q     <= lf_d;
      seed_q   <= seed_d;
      mem_q    <= mem_d;
      held_q   <= held_d;
    end
  end

endmodule

// ===== hdl/actuator_noise_and_bias_learning_top.sv =====
// Actuator noise and rest duty learning block, with output duty selection.
// Uses anbl_pkg, anbl_front, anbl_fifo and anbl_back.
//
// Use:
//   Input items (mode, servo_enable, cam_position, pid_duty) enter as queue
//   pushes: a beat is taken at an edge with push high and full low. Results
//   leave as queue pops: while empty is low the oldest result sits on
//   out_data_o and is taken at an edge with pop high.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i);
//   write only while no item is in flight.
//   Throughput is one item per clock while the result queue keeps draining.
//   The edge that takes an input beat writes the command queue; once the
//   result queue has room, the back end pops it, runs the learning state
//   and writes the result queue. The learning state is a single register
//   set updated once per item, so each item sees the one before.
//   When the receiver stalls the result queue fills, the back end holds, the
//   command queue fills, and full rises; nothing is dropped.
//   Reset clears all learning state, both queues, and loads the register
//   defaults (sample target ten, search limit 1023, the rest zero).
module actuator_noise_and_bias_learning_top import anbl_pkg::*; #(
  parameter int unsigned CmdDepth = 2,
  parameter int unsigned ResDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  anbl_in_t    in_data_i,
  output logic        empty,
  input  logic        pop,
  output anbl_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  anbl_cfg_t cfg_q;
  anbl_cmd_t cmd_in, cmd_out;
  anbl_out_t res;
  logic      cmd_empty, cmd_pop, res_full, res_push;

  // Register file: take the low bits of the write data for each register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.initial_duty        <= 10'd0;
      cfg_q.noise_sample_target <= 8'd10;
      cfg_q.default_noise       <= 8'd0;
      cfg_q.duty_step           <= 10'd0;
      cfg_q.duty_search_limit   <= 10'd1023;
      cfg_q.ticks_per_step      <= 8'd0;
      cfg_q.bench_enable        <= 1'b0;
      cfg_q.bench_duty          <= 16'd0;
    end else if (cfg_we_i) begin
      case (anbl_reg_e'(cfg_idx_i))
        REG_INITIAL_DUTY:      cfg_q.initial_duty        <= cfg_data_i[9:0];
        REG_NOISE_TARGET:      cfg_q.noise_sample_target <= cfg_data_i[7:0];
        REG_DEFAULT_NOISE:     cfg_q.default_noise       <= cfg_data_i[7:0];
        REG_DUTY_STEP:         cfg_q.duty_step           <= cfg_data_i[9:0];
        REG_DUTY_SEARCH_LIMIT: cfg_q.duty_search_limit   <= cfg_data_i[9:0];
        REG_TICKS_PER_STEP:    cfg_q.ticks_per_step      <= cfg_data_i[7:0];
        REG_BENCH_ENABLE:      cfg_q.bench_enable        <= cfg_data_i[0];
        REG_BENCH_DUTY:        cfg_q.bench_duty          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: classify the beat before it is queued.
  anbl_front u_front (
    .item_i (in_data_i),
    .cmd_o  (cmd_in)
  );

  // Decouple acceptance from the learning engine.
  anbl_fifo #(
    .T     (anbl_cmd_t),
    .Depth (CmdDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // Back: advance the learning state once per popped command.
  anbl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // Hold finished results until the receiver pops them.
  anbl_fifo #(
    .T     (anbl_out_t),
    .Depth (ResDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

endmodule

// ===== hdl/anbl_checker.sv =====
// Port-level checks for the noise and bias learning block, bound to its top.
// Depends on anbl_pkg and the assertion macro header.
`include "actuator_noise_and_bias_learning_top_assert.svh"

module anbl_checker import anbl_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input anbl_out_t   out_data_o
);

  `ANBL_ASSERT_NOW(a_done_is_both, clk_i, rst_ni, !empty, out_data_o.learning_done == (out_data_o.noise_learned && out_data_o.rest_duty_learned), "learning_done differs from both flags")
  `ANBL_ASSERT_NOW(a_rest_needs_noise, clk_i, rst_ni, !empty && out_data_o.rest_duty_learned, out_data_o.noise_learned, "rest duty learned before noise")
  `ANBL_ASSERT_NOW(a_noise_range, clk_i, rst_ni, !empty, out_data_o.noise_level <= PosSat, "noise level above saturation")
  `ANBL_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_data_o), "stalled result changed")

endmodule

bind actuator_noise_and_bias_learning_top anbl_checker u_anbl_checker (.*);

// ===== sim/tb_actuator_noise_and_bias_learning_top.sv =====
// Self-checking testbench for actuator_noise_and_bias_learning_top.
// Holds its own model of the noise and rest duty learning, and checks each result beat field by field.
// Depends on anbl_pkg and the RTL under hdl only.
module tb_actuator_noise_and_bias_learning_top;
  timeunit 1ns;
  timeprecision 1ps;
  import anbl_pkg::*;

  localparam int unsigned SeedScale   = 64;
  localparam int unsigned IdlePercent = 38;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomTicks = 800;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned DrainCycles = 8;
  localparam logic        ModeTick    = 1'b0;
  localparam logic        ModeRestart = 1'b1;

  // Block ports: every input starts at a known value.
  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        push      = 1'b0;
  logic        full;
  anbl_in_t    stim_beat = '0;
  logic        empty;
  logic        pop       = 1'b0;
  anbl_out_t   result_beat;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_idx   = '0;
  logic [15:0] cfg_data  = '0;

  // Model copy of the registers, at their reset defaults.
  anbl_cfg_t cfg_model = '{initial_duty: 10'd0, noise_sample_target: 8'd10,
                           default_noise: 8'd0, duty_step: 10'd0,
                           duty_search_limit: 10'd1023, ticks_per_step: 8'd0,
                           bench_enable: 1'b0, bench_duty: 16'd0};

  // Model copy of the learning state, all zero after reset.
  logic [9:0]  search_duty  = '0;
  logic [7:0]  wait_count   = '0;
  logic [6:0]  high_peak    = '0;
  logic [6:0]  low_peak     = '0;
  logic [6:0]  sample_count = '0;
  logic [6:0]  noise_value  = '0;
  logic        noise_flag   = 1'b0;
  logic        learned_flag = 1'b0;
  logic [15:0] seed_value   = '0;
  logic [15:0] seed_memory  = '0;
  logic [9:0]  held_duty    = '0;

  // Reports still owed by the block, oldest first.
  anbl_out_t   pending_reports[$];
  anbl_out_t   oldest_report;

  int unsigned error_count       = 0;
  int unsigned beats_sent        = 0;
  int unsigned active_beats      = 0;
  int unsigned results_checked   = 0;
  int unsigned rest_learned_seen = 0;
  int unsigned settings_applied  = 0;
  int unsigned cycle_count       = 0;
  bit          steady_flow       = 1'b0;

  always #5ns clk_i = ~clk_i;

  actuator_noise_and_bias_learning_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (stim_beat),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (result_beat),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Advance the model by one accepted item and return the report it causes.
  function automatic anbl_out_t step_learning(anbl_in_t item);
    int unsigned pos_sat;
    int unsigned count_next;
    int unsigned back;
    int unsigned duty_next;
    int unsigned selected;
    anbl_out_t   report;
    if (item.mode == ModeRestart) begin
      // Restart: clear learning, keep noise, seed memory and held duty.
      search_duty  = cfg_model.initial_duty;
      wait_count   = '0;
      high_peak    = '0;
      low_peak     = '0;
      sample_count = '0;
      noise_flag   = 1'b0;
      learned_flag = 1'b0;
      seed_value   = '0;
    end else if (item.servo_enable) begin
      if (!noise_flag) begin
        pos_sat = (item.cam_position > PosSat) ? PosSat : item.cam_position;
        if (sample_count == 0) begin
          high_peak = 7'(pos_sat);
          low_peak  = 7'(pos_sat);
        end else begin
          // The high peak compares the raw position, the low peak the clipped one.
          if (item.cam_position > high_peak) high_peak = 7'(pos_sat);
          if (pos_sat < low_peak) low_peak = 7'(pos_sat);
        end
        count_next   = sample_count + 1;
        sample_count = (count_next > CountSat) ? CountSat : 7'(count_next);
        if (sample_count >= cfg_model.noise_sample_target) begin
          if (cfg_model.noise_sample_target == 0) begin
            noise_value = (cfg_model.default_noise > PosSat) ? PosSat
                                                             : cfg_model.default_noise[6:0];
          end else begin
            noise_value = (high_peak > low_peak) ? 7'(high_peak - low_peak) : '0;
          end
          noise_flag = 1'b1;
        end
      end
      // The tick that learns the noise also runs one duty search step.
      if (noise_flag && !learned_flag) begin
        if ((int'(noise_value) * 2 < int'(item.cam_position)) ||
            (search_duty > cfg_model.duty_search_limit)) begin
          back = (search_duty > cfg_model.duty_step) ?
                 int'(search_duty) - int'(cfg_model.duty_step) : 0;
          learned_flag = 1'b1;
          seed_value   = 16'(back * SeedScale);
          seed_memory  = seed_value;
          search_duty  = 10'(back);
        end else begin
          learned_flag = 1'b0;
          seed_memory  = seed_value;
          if (wait_count < cfg_model.ticks_per_step) begin
            wait_count = wait_count + 8'd1;
          end else begin
            duty_next   = int'(search_duty) + int'(cfg_model.duty_step);
            search_duty = (duty_next > DutyMax) ? DutyMax : 10'(duty_next);
            wait_count  = '0;
          end
        end
        if (wait_count > WaitSat) wait_count = WaitSat;
      end
      if (cfg_model.bench_enable) selected = cfg_model.bench_duty;
      else if (learned_flag)      selected = item.pid_duty;
      else                        selected = search_duty;
      held_duty = (selected > DutyMax) ? DutyMax : 10'(selected);
    end
    report.duty_out          = held_duty;
    report.noise_learned     = noise_flag;
    report.rest_duty_learned = learned_flag;
    report.learning_done     = noise_flag & learned_flag;
    report.noise_level       = noise_value;
    report.current_duty      = search_duty;
    report.integral_seed     = seed_value;
    report.integral_memory   = seed_memory;
    return report;
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= ReportLimit) $display("%s", msg);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      note_error($sformatf("mismatch on result %0d, %s: expected %0d, got %0d",
                           results_checked, name, want, got));
    end
  endfunction

  // Mostly small values, with both ends of the range turning up often.
  function automatic int unsigned pick_value(int unsigned top, int unsigned usual);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return 0;
    if (roll < 30) return top;
    return $urandom_range(usual, 0);
  endfunction

  // Offer one beat, after a random gap unless the flow is steady, and hold it until the block takes it.
  // Push stays high on return so back-to-back beats follow without push dropping in between.
  task automatic send_item(input logic mode, input logic enable,
                           input logic [15:0] pos, input logic [15:0] pid);
    anbl_in_t beat;
    beat = '{mode: mode, servo_enable: enable, cam_position: pos, pid_duty: pid};
    while (!steady_flow && $urandom_range(99) < IdlePercent) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    stim_beat <= beat;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_reports.push_back(step_learning(beat));
    beats_sent++;
    if (mode == ModeRestart || enable) active_beats++;
  endtask

  // Drop push and hold until every owed report has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Write all eight registers on consecutive edges while the block is idle.
  task automatic apply_config(input anbl_cfg_t setting);
    anbl_reg_e idx;
    wait_drained();
    idx = idx.first();
    do begin
      cfg_we  <= 1'b1;
      cfg_idx <= idx;
      case (idx)
        REG_INITIAL_DUTY:      cfg_data <= 16'(setting.initial_duty);
        REG_NOISE_TARGET:      cfg_data <= 16'(setting.noise_sample_target);
        REG_DEFAULT_NOISE:     cfg_data <= 16'(setting.default_noise);
        REG_DUTY_STEP:         cfg_data <= 16'(setting.duty_step);
        REG_DUTY_SEARCH_LIMIT: cfg_data <= 16'(setting.duty_search_limit);
        REG_TICKS_PER_STEP:    cfg_data <= 16'(setting.ticks_per_step);
        REG_BENCH_ENABLE:      cfg_data <= 16'(setting.bench_enable);
        REG_BENCH_DUTY:        cfg_data <= setting.bench_duty;
        default:               cfg_data <= '0;
      endcase
      @(posedge clk_i);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we    <= 1'b0;
    cfg_model = setting;
    settings_applied++;
  endtask

  // Straight after reset, with the default registers: a disabled tick only
  // reports the cleared state, and a restart ignores its other fields.
  task automatic test_reset_state();
    send_item(ModeTick, 1'b0, 16'hFFFF, 16'hFFFF);
    send_item(ModeRestart, 1'b1, 16'hFFFF, 16'hFFFF);
  endtask

  // A zero sample target takes the default noise, clipped at 106. A search
  // duty already above the limit is caught on the same tick, and the back-off
  // clamps at zero. Once learned, the PID duty is selected and clipped.
  task automatic test_default_noise();
    apply_config('{initial_duty: 10'd1023, noise_sample_target: 8'd0,
                   default_noise: 8'd255, duty_step: 10'd1023,
                   duty_search_limit: 10'd0, ticks_per_step: 8'd0,
                   bench_enable: 1'b0, bench_duty: 16'd0});
    send_item(ModeRestart, 1'b0, 16'h0000, 16'h0000);
    send_item(ModeTick, 1'b1, 16'h0000, 16'hFFFF);
    send_item(ModeTick, 1'b1, 16'h0000, 16'h0000);
  endtask

  // Peak tracking over four samples (one clipped from above), the duty search
  // on the same tick, the wait between steps, a disabled tick mid-search, and
  // detection just above twice the noise.
  task automatic test_peak_search();
    apply_config('{initial_duty: 10'd0, noise_sample_target: 8'd4,
                   default_noise: 8'd0, duty_step: 10'd7,
                   duty_search_limit: 10'd1023, ticks_per_step: 8'd2,
                   bench_enable: 1'b0, bench_duty: 16'd0});
    send_item(ModeRestart, 1'b1, 16'h0000, 16'h0000);
    send_item(ModeTick, 1'b1, 16'hFFFF, 16'($urandom));
    send_item(ModeTick, 1'b1, 16'd0, 16'($urandom));
    send_item(ModeTick, 1'b1, 16'd50, 16'($urandom));
    send_item(ModeTick, 1'b1, 16'd106, 16'($urandom));
    repeat (3) send_item(ModeTick, 1'b1, 16'd212, 16'($urandom));
    send_item(ModeTick, 1'b0, 16'hFFFF, 16'hFFFF);
    send_item(ModeTick, 1'b1, 16'd213, 16'd1023);
  endtask

  // A target above the saturated sample count never learns the noise, so the
  // search never steps, even with its wait set above saturation, and the bench duty overrides the output.
  task automatic test_bench_and_saturation();
    apply_config('{initial_duty: 10'd1023, noise_sample_target: 8'd255,
                   default_noise: 8'd0, duty_step: 10'd1,
                   duty_search_limit: 10'd1023, ticks_per_step: 8'd255,
                   bench_enable: 1'b1, bench_duty: 16'hFFFF});
    send_item(ModeRestart, 1'b0, 16'hFFFF, 16'h0000);
    repeat (3) send_item(ModeTick, 1'b1, 16'($urandom), 16'($urandom));
  endtask

  // Phases of random registers, each opened by a restart and followed mostly
  // by enabled ticks whose positions sit near the noise band, with stray
  // restarts, disabled ticks and full-range values mixed in.
  task automatic test_random_learning();
    anbl_cfg_t   setting;
    int unsigned start_beats;
    int unsigned phase;
    int unsigned roll;
    logic [15:0] pos;
    logic [15:0] pid;
    start_beats = active_beats;
    phase       = 0;
    while (active_beats - start_beats < RandomTicks) begin
      setting.initial_duty        = 10'(pick_value(1023, 1023));
      setting.noise_sample_target = ($urandom_range(9) == 0) ? 8'($urandom_range(101, 99))
                                                             : 8'(pick_value(255, 12));
      setting.default_noise       = 8'(pick_value(255, 255));
      setting.duty_step           = 10'(pick_value(1023, 40));
      setting.duty_search_limit   = 10'(pick_value(1023, 1023));
      setting.ticks_per_step      = ($urandom_range(9) == 0) ? 8'($urandom_range(201, 199))
                                                             : 8'(pick_value(255, 4));
      setting.bench_enable        = ($urandom_range(9) == 0);
      setting.bench_duty          = 16'(pick_value(65535, 2000));
      // One phase runs with neither side idling.
      steady_flow = (phase == 3);
      apply_config(setting);
      send_item(ModeRestart, 1'($urandom), 16'($urandom), 16'($urandom));
      repeat ($urandom_range(120, 40)) begin
        roll = $urandom_range(99);
        pid  = $urandom_range(1) ? 16'($urandom_range(1100, 0)) : 16'($urandom);
        if (roll < 4) begin
          send_item(ModeRestart, 1'($urandom), 16'($urandom), pid);
        end else if (roll < 12) begin
          send_item(ModeTick, 1'b0, 16'($urandom), pid);
        end else begin
          roll = $urandom_range(99);
          if (roll < 60)      pos = 16'($urandom_range(130, 0));
          else if (roll < 85) pos = 16'($urandom_range(260, 0));
          else                pos = 16'($urandom);
          send_item(ModeTick, 1'b1, pos, pid);
        end
      end
      phase++;
    end
    steady_flow = 1'b0;
  endtask

  // Result side: check the beat taken at this edge, then choose whether to
  // pop at the next one.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_reports.size() == 0) begin
        note_error($sformatf("result beat with no item waiting: %h", result_beat));
      end else begin
        oldest_report = pending_reports.pop_front();
        check_field("duty_out", oldest_report.duty_out, result_beat.duty_out);
        check_field("noise_learned", oldest_report.noise_learned,
                    result_beat.noise_learned);
        check_field("rest_duty_learned", oldest_report.rest_duty_learned,
                    result_beat.rest_duty_learned);
        check_field("learning_done", oldest_report.learning_done,
                    result_beat.learning_done);
        check_field("noise_level", oldest_report.noise_level, result_beat.noise_level);
        check_field("current_duty", oldest_report.current_duty, result_beat.current_duty);
        check_field("integral_seed", oldest_report.integral_seed,
                    result_beat.integral_seed);
        check_field("integral_memory", oldest_report.integral_memory,
                    result_beat.integral_memory);
        if (oldest_report.rest_duty_learned) rest_learned_seen++;
        results_checked++;
      end
    end
    pop <= steady_flow || ($urandom_range(99) >= IdlePercent);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d reports still owed",
               cycle_count, pending_reports.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_default_noise();
    test_peak_search();
    test_bench_and_saturation();
    test_random_learning();
    wait_drained();
    // Let any stray result beat surface before the verdict.
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d beats (%0d restarts or enabled ticks) over %0d register settings.",
             beats_sent, active_beats, settings_applied);
    $display("Checked %0d reports, %0d with the rest duty learned; %0d errors.",
             results_checked, rest_learned_seen, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/anbl_pkg.sv
hdl/anbl_fifo.sv
hdl/anbl_front.sv
hdl/anbl_back.sv
hdl/actuator_noise_and_bias_learning_top.sv
hdl/anbl_checker.sv
sim/tb_actuator_noise_and_bias_learning_top.sv
